@@ rtl/bf_pkg.sv @@
// shared types and constants for the blowfish cipher core
// no dependencies; used by all rtl files of the block
package bf_pkg;

    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int BANKS   = 4;
    localparam int BANK_AW = 8;
    localparam int IDX_W   = 10;

    typedef enum logic [1:0] {
        OP_ENCIPHER = 2'd0,
        OP_DECIPHER = 2'd1,
        OP_WRITE_P  = 2'd2,
        OP_WRITE_S  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_LOAD  = 3'b010,
        ST_ROUND = 3'b100
    } state_t;

    typedef logic [WORD_W-1:0]                word_t;
    typedef logic [BANKS-1:0][WORD_W-1:0]     sbox_data_t;
    typedef logic [BANKS-1:0][BANK_AW-1:0]    sbox_addr_t;

    typedef struct packed {
        logic               en;
        logic [1:0]         bank;
        logic [BANK_AW-1:0] addr;
        word_t              data;
    } sbox_wr_t;

    // bank 0 takes the most significant byte, bank 3 the least
    function automatic sbox_addr_t sbox_addr(input word_t x);
        sbox_addr_t a;
        a[0] = x[31:24];
        a[1] = x[23:16];
        a[2] = x[15:8];
        a[3] = x[7:0];
        return a;
    endfunction

endpackage

@@ rtl/bf_sbox_mem.sv @@
// four 256-word s-box banks, one write port, one registered read per bank
// depends on bf_pkg
module bf_sbox_mem (
    input  logic               clk,
    input  bf_pkg::sbox_wr_t   wr,
    input  bf_pkg::sbox_addr_t rd_addr,
    output bf_pkg::sbox_data_t rd_data
);
    import bf_pkg::*;

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic [WORD_W-1:0] bank_mem [2**BANK_AW];
        logic [WORD_W-1:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (wr.en && (wr.bank == 2'(b)))
            begin
                bank_mem[wr.addr] <= wr.data;
            end
            rd_reg <= bank_mem[rd_addr[b]];
        end

        assign rd_data[b] = rd_reg;
    end

endmodule

@@ rtl/bf_feistel.sv @@
// shared feistel round datapath: round function f, half update, output whitening
// depends on bf_pkg
module bf_feistel (
    input  bf_pkg::sbox_data_t sdata,
    input  bf_pkg::word_t      r_in,
    input  bf_pkg::word_t      lx_in,
    input  bf_pkg::word_t      p_word,
    input  bf_pkg::word_t      pa,
    input  bf_pkg::word_t      pb,
    output bf_pkg::word_t      lx_round,
    output bf_pkg::word_t      out_l,
    output bf_pkg::word_t      out_r
);
    import bf_pkg::*;

    word_t f_val;
    word_t new_l;

    always_comb
    begin
        f_val    = ((sdata[0] + sdata[1]) ^ sdata[2]) + sdata[3];
        new_l    = r_in ^ f_val;
        lx_round = new_l ^ p_word;
        // final swap folded in: left gets the old left half, right the new one
        out_l    = lx_in ^ pa;
        out_r    = new_l ^ pb;
    end

endmodule

@@ rtl/blowfish_block_cipher_top.sv @@
// blowfish block cipher core: sequencer, p-array registers, s-box banks
// depends on bf_pkg, bf_sbox_mem, bf_feistel
//
// channel   dir  tdata fields (lsb up)                               tuser
// s_axis    in   table_index[9:0] table_word[41:10]                  opcode[1:0]
//                block_left[73:42] block_right[105:74] zero[111:106]
// m_axis    out  out_left[31:0] out_right[63:32]                     -
//
// encipher/decipher: a load state, then one round per cycle until the result
// lands in the output register, set by the registered s-box read feeding the
// next round's address; table writes give no result. rst_n clears only
// control state; tables are undefined until written. input is taken only in
// idle; the last round holds while an earlier result still waits on m_axis.
module blowfish_block_cipher_top #(
    parameter int ROUNDS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,   // table_index, table_word, block_left, block_right
    input  logic [1:0]   s_axis_tuser,   // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata    // out_left, out_right
);
    import bf_pkg::*;

    localparam int PWORDS = ROUNDS + 2;
    localparam int PW     = $clog2(PWORDS);
    localparam int KW     = $clog2(ROUNDS + 1);

    // input field split
    logic [IDX_W-1:0] in_index;
    word_t            in_word;
    word_t            in_left;
    word_t            in_right;
    opcode_t          in_op;

    assign in_index = s_axis_tdata[9:0];
    assign in_word  = s_axis_tdata[41:10];
    assign in_left  = s_axis_tdata[73:42];
    assign in_right = s_axis_tdata[105:74];
    assign in_op    = opcode_t'(s_axis_tuser);

    state_t        state_reg, state_next;
    logic [KW-1:0] k_reg;
    logic          dec_reg;
    word_t         lx_reg;   // left half already xored with its subkey
    word_t         r_reg;
    logic          out_valid_reg;
    word_t         out_l_reg;
    word_t         out_r_reg;

    // p-array in flops, one indexed read per cycle plus the fixed whitening words
    word_t p_reg [PWORDS];

    logic          in_xfer;
    logic          last_round;
    logic          advance;
    logic [PW-1:0] p_idx;
    word_t         p_cur;
    word_t         pa;
    word_t         pb;
    word_t         lx_load;
    word_t         lx_round;
    word_t         lx_sel;
    word_t         res_l;
    word_t         res_r;
    sbox_wr_t      s_wr;
    sbox_data_t    s_data;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign last_round    = (state_reg == ST_ROUND) && (k_reg == KW'(ROUNDS));
    assign advance       = !last_round || !out_valid_reg || m_axis_tready;

    // subkey order runs backward when deciphering
    assign p_idx = dec_reg ? (PW'(ROUNDS + 1) - PW'(k_reg)) : PW'(k_reg);
    assign p_cur = p_reg[p_idx];
    assign pa    = dec_reg ? p_reg[0] : p_reg[ROUNDS + 1];
    assign pb    = dec_reg ? p_reg[1] : p_reg[ROUNDS];

    assign lx_load = lx_reg ^ p_cur;

    bf_feistel u_feistel (
        .sdata    (s_data),
        .r_in     (r_reg),
        .lx_in    (lx_reg),
        .p_word   (p_cur),
        .pa       (pa),
        .pb       (pb),
        .lx_round (lx_round),
        .out_l    (res_l),
        .out_r    (res_r)
    );

    // address source for the s-box read that feeds the next cycle
    always_comb
    begin
        unique case (state_reg)
            ST_LOAD:  lx_sel = lx_load;
            ST_ROUND: lx_sel = (advance && !last_round) ? lx_round : lx_reg;
            default:  lx_sel = lx_reg;
        endcase
    end

    always_comb
    begin
        s_wr.en   = in_xfer && (in_op == OP_WRITE_S);
        s_wr.bank = in_index[9:8];
        s_wr.addr = in_index[7:0];
        s_wr.data = in_word;
    end

    bf_sbox_mem u_sbox (
        .clk     (clk),
        .wr      (s_wr),
        .rd_addr (sbox_addr(lx_sel)),
        .rd_data (s_data)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && ((in_op == OP_ENCIPHER) || (in_op == OP_DECIPHER)))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (last_round && advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                k_reg <= '0;
            end
            else if ((state_reg == ST_LOAD) || ((state_reg == ST_ROUND) && !last_round))
            begin
                k_reg <= k_reg + KW'(1);
            end
            if (last_round && advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            dec_reg <= (in_op == OP_DECIPHER);
            lx_reg  <= in_left;
            r_reg   <= in_right;
        end
        else if (state_reg == ST_LOAD)
        begin
            lx_reg <= lx_load;
        end
        else if ((state_reg == ST_ROUND) && !last_round)
        begin
            lx_reg <= lx_round;
            r_reg  <= lx_reg;
        end

        if (last_round && advance)
        begin
            out_l_reg <= res_l;
            out_r_reg <= res_r;
        end

        // out-of-range p writes are dropped
        if (in_xfer && (in_op == OP_WRITE_P) && (in_index < IDX_W'(PWORDS)))
        begin
            p_reg[in_index[PW-1:0]] <= in_word;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_r_reg, out_l_reg};

endmodule
